/* src/bls_pkg.sv */
// shared types and codes for the bounded lifo stack unit
package bls_pkg;

    localparam int MODE_W   = 2;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    localparam logic [WORD_W-1:0] WORD_NONE = '1;

    // shift command shared by every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } shift_t;

    // one result transaction
    typedef struct packed {
        logic                       is_empty;
        logic                       is_full;
        logic [STATUS_W-1:0]        status;
        logic signed [WORD_W-1:0]   read_data;
    } result_t;

endpackage

/* src/bls_cell.sv */
// one stack cell: holds a word, takes it from the upper or lower neighbor on a shift
module bls_cell (
    input  logic                              aclk,
    input  bls_pkg::shift_t                   shift,
    input  logic signed [bls_pkg::WORD_W-1:0] from_up,
    input  logic signed [bls_pkg::WORD_W-1:0] from_down,
    output logic signed [bls_pkg::WORD_W-1:0] word_q
);
    import bls_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (shift.push) begin
            word_next = from_up;
        end else if (shift.pop) begin
            word_next = from_down;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word_q = word_reg;

endmodule

/* src/bls_out_buf.sv */
// output register with skid stage for result transactions
module bls_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  bls_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output bls_pkg::result_t out_data
);
    import bls_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (in_valid) begin
                main_reg <= in_data;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end else if (in_valid && !skid_valid_reg) begin
            if (!main_valid_reg) begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

endmodule

/* src/bounded_lifo_stack_unit.sv */
// top level of the bounded lifo stack unit: cell chain, count control, output buffer
//
// usage
// - input channel s_*: one transaction per operation; s_tuser carries the mode
//   (push, pop, peek), s_tdata the push word and the peek depth index
// - result channel m_*: exactly one result transaction per input transaction,
//   in order: popped or peeked word (all ones on push, error or unused mode),
//   status, full and empty flags as seen after the operation
// - cfg_wr_en / cfg_wr_data write the capacity register; write only while idle;
//   capacity zero acts as one, values above DEPTH act as DEPTH
// - the stack is a chain of DEPTH cells, cell 0 holding the top entry; a push
//   shifts every cell one place down, a pop one place up, all cells together
// - one transaction per cycle, sustained while m_tready holds; the result
//   reaches m_* through the output register (one register stage)
// - a stalled receiver fills the output register and then a one-entry skid
//   stage; s_tready drops only once both hold results
// - reset empties the stack and sets capacity to 16; entry words are not cleared
//   and are never read before they are written
// - peek reaches the top min(DEPTH, 31) cells, the reach of the 5-bit index
module bounded_lifo_stack_unit #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // capacity register
    input  logic                          cfg_wr_en,
    input  logic [4:0]                    cfg_wr_data,
    // input transactions
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,  // push_value[31:0], depth_index[36:32], zero
    input  logic [bls_pkg::MODE_W-1:0]    s_tuser,  // mode[1:0]
    // result transactions
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata   // read_data[31:0], status[33:32],
                                                    // is_full[34], is_empty[35], zero
);
    import bls_pkg::*;

    // count width holds 0..DEPTH; compare width also holds the 5-bit capacity
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > INDEX_W) ? CW : INDEX_W;
    // cells the 5-bit peek index can reach
    localparam int PN = (DEPTH < 31) ? DEPTH : 31;

    // input field unpacking
    logic [MODE_W-1:0]        in_mode;
    logic signed [WORD_W-1:0] in_value;
    logic [INDEX_W-1:0]       in_index;

    assign in_mode  = s_tuser;
    assign in_value = s_tdata[WORD_W-1:0];
    assign in_index = s_tdata[WORD_W+INDEX_W-1:WORD_W];

    // capacity register and effective capacity
    logic [INDEX_W-1:0] cap_reg;
    logic [EW-1:0]      cap_x;
    logic [EW-1:0]      cap_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 5'd16;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign cap_x = EW'(cap_reg);

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = EW'(1);
        end else if (cap_x > EW'(DEPTH)) begin
            cap_eff = EW'(DEPTH);
        end else begin
            cap_eff = cap_x;
        end
    end

    // entry count
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [EW-1:0] count_x;
    logic [EW-1:0] count_next_x;

    assign count_x      = EW'(count_reg);
    assign count_next_x = EW'(count_next);

    // transaction handshake toward the output buffer
    logic    buf_ready;
    logic    in_fire;
    result_t res;

    assign s_tready = buf_ready;
    assign in_fire  = s_tvalid && buf_ready;

    // cell chain
    logic signed [WORD_W-1:0] cell_q [DEPTH];
    shift_t                   shift;

    // peek selection over the reachable cells
    logic [INDEX_W-1:0]       peek_pos;
    logic signed [WORD_W-1:0] peek_word;

    assign peek_pos = in_index - INDEX_W'(1);

    always_comb begin
        peek_word = WORD_NONE;
        for (int i = 0; i < PN; i++) begin
            if (peek_pos == INDEX_W'(i)) begin
                peek_word = cell_q[i];
            end
        end
    end

    // operation decode
    always_comb begin
        shift         = '0;
        count_next    = count_reg;
        res.read_data = WORD_NONE;
        res.status    = ST_OK;
        if (in_fire) begin
            unique case (in_mode)
                MODE_PUSH: begin
                    if (count_x >= cap_eff) begin
                        res.status = ST_OVERFLOW;
                    end else begin
                        shift.push = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_POP: begin
                    if (count_reg == '0) begin
                        res.status = ST_UNDERFLOW;
                    end else begin
                        shift.pop     = 1'b1;
                        count_next    = count_reg - CW'(1);
                        res.read_data = cell_q[0];
                    end
                end
                MODE_PEEK: begin
                    if (in_index == '0 || EW'(in_index) > count_x) begin
                        res.status = ST_BAD_INDEX;
                    end else begin
                        res.read_data = peek_word;
                    end
                end
                default: begin
                    // unused mode: no operation
                end
            endcase
        end
        res.is_full  = (count_next_x >= cap_eff);
        res.is_empty = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // push feeds cell 0 from the input, pop pulls every cell up one place
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [WORD_W-1:0] up_word;
            logic signed [WORD_W-1:0] down_word;
            if (g == 0) begin : g_top
                assign up_word = in_value;
            end else begin : g_mid
                assign up_word = cell_q[g-1];
            end
            if (g == DEPTH - 1) begin : g_bottom
                assign down_word = cell_q[g];
            end else begin : g_upper
                assign down_word = cell_q[g+1];
            end
            bls_cell u_cell (
                .aclk      (aclk),
                .shift     (shift),
                .from_up   (up_word),
                .from_down (down_word),
                .word_q    (cell_q[g])
            );
        end
    endgenerate

    // result register and skid stage
    result_t out_res;

    bls_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_fire),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {4'd0, out_res.is_empty, out_res.is_full, out_res.status,
                      out_res.read_data};

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(count_reg) <= EW'(DEPTH))
        else $error("entry count beyond depth");

    a_ready_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_mode == MODE_POP && count_reg != '0)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not lower the count");

    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && in_mode == MODE_PUSH && count_x >= cap_eff)
        |=> $stable(count_reg))
        else $error("overflowing push changed the count");

endmodule
